>>> rtl/core/dmpid_pkg.sv
// ============================================================================
// dmpid_pkg
// Shared types, widths and register indexes for the dual-mode PID controller.
// ============================================================================
package dmpid_pkg;

    // Fixed field widths
    localparam int IN_WIDTH    = 16;
    localparam int IN_FRAC     = 4;
    localparam int GAIN_WIDTH  = 16;
    localparam int LIMIT_WIDTH = 15;
    localparam int OUT_WIDTH   = 16;
    localparam int ERR_WIDTH   = IN_WIDTH + 1;
    localparam int PROD_WIDTH  = GAIN_WIDTH + ERR_WIDTH + 2;

    // Parameter defaults
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int ACC_WIDTH_DEF      = 40;

    // Heading wrap in Q11.4
    localparam int HALF_TURN = 180 << IN_FRAC;
    localparam int FULL_TURN = 360 << IN_FRAC;

    // Reset values of the limit registers
    localparam logic [LIMIT_WIDTH-1:0] RESET_OUT_LIMIT = 15'd1600;
    localparam logic [LIMIT_WIDTH-1:0] RESET_I_LIMIT   = 15'd800;

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WRAP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KP          = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KI          = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_KD          = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_I_LIMIT     = 3'd6;

    // Mode codes
    localparam logic MODE_INCREMENTAL = 1'b0;
    localparam logic MODE_POSITIONAL  = 1'b1;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] setpoint;
        logic signed [IN_WIDTH-1:0] measured;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] drive;
        logic signed [OUT_WIDTH-1:0] integral_term;
        logic                        clamped;
    } out_item_t;

    typedef struct packed {
        logic                          mode;
        logic                          wrap_enable;
        logic signed [GAIN_WIDTH-1:0]  kp;
        logic signed [GAIN_WIDTH-1:0]  ki;
        logic signed [GAIN_WIDTH-1:0]  kd;
        logic        [LIMIT_WIDTH-1:0] out_limit;
        logic        [LIMIT_WIDTH-1:0] i_limit;
    } cfg_t;

    // Error sample with its history
    typedef struct packed {
        logic signed [ERR_WIDTH-1:0] e0;
        logic signed [ERR_WIDTH-1:0] e1;
        logic signed [ERR_WIDTH-1:0] e2;
    } err_t;

    // Gain products: proportional, integral, derivative
    typedef struct packed {
        logic signed [PROD_WIDTH-1:0] pa;
        logic signed [PROD_WIDTH-1:0] pi;
        logic signed [PROD_WIDTH-1:0] pd;
    } prod_t;

endpackage

>>> rtl/core/dmpid_err.sv
// ============================================================================
// dmpid_err
// Error stage: forms setpoint - measured, optional +/-180 degree fold, and
// keeps the two-deep error history.
// ============================================================================
module dmpid_err (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wrap_enable,
    input  logic              ld,
    input  dmpid_pkg::in_item_t in_item,
    output dmpid_pkg::err_t     err
);
    import dmpid_pkg::*;

    localparam int RW         = (IN_WIDTH > 13) ? IN_WIDTH : 13;
    localparam int WRAP_STEPS = (IN_WIDTH > 13) ? IN_WIDTH - 12 : 1;

    logic signed [ERR_WIDTH-1:0] e_raw;
    logic signed [ERR_WIDTH-1:0] e_next;
    logic signed [ERR_WIDTH-1:0] last_err_reg;
    logic signed [ERR_WIDTH-1:0] older_err_reg;
    err_t                        err_reg;
    err_t                        err_next;

    // Fold into [-180,+180] by whole turns; exactly +/-180 stays
    function automatic logic signed [ERR_WIDTH-1:0] wrap_err(
        input logic signed [ERR_WIDTH-1:0] e
    );
        logic [RW-1:0]               r;
        logic signed [ERR_WIDTH-1:0] fold;
        logic                        big;
        big = (e > ERR_WIDTH'(HALF_TURN)) || (e < -ERR_WIDTH'(HALF_TURN));
        r   = (e < 0) ? RW'(-e) : RW'(e);
        r   = r - RW'(HALF_TURN + 1);
        // restoring remainder by the turn size, one compare per bit
        for (int j = WRAP_STEPS - 1; j >= 0; j--) begin
            if (r >= RW'(FULL_TURN << j)) begin
                r = r - RW'(FULL_TURN << j);
            end
        end
        fold = signed'(ERR_WIDTH'(r)) - ERR_WIDTH'(HALF_TURN - 1);
        if (!big) begin
            return e;
        end else if (e > 0) begin
            return fold;
        end else begin
            return -fold;
        end
    endfunction

    always_comb begin
        e_raw       = ERR_WIDTH'(in_item.setpoint) - ERR_WIDTH'(in_item.measured);
        e_next      = wrap_enable ? wrap_err(e_raw) : e_raw;
        err_next.e0 = e_next;
        err_next.e1 = last_err_reg;
        err_next.e2 = older_err_reg;
    end

    // History shifts once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            older_err_reg <= '0;
        end else if (ld) begin
            last_err_reg  <= e_next;
            older_err_reg <= last_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            err_reg <= err_next;
        end
    end

    assign err = err_reg;

endmodule

>>> rtl/core/dmpid_mult.sv
// ============================================================================
// dmpid_mult
// Multiply stage: error and error differences times the three gains, registered.
// ============================================================================
module dmpid_mult (
    input  logic              aclk,
    input  logic              ld,
    input  dmpid_pkg::cfg_t   cfg,
    input  dmpid_pkg::err_t   err,
    output dmpid_pkg::prod_t  prod
);
    import dmpid_pkg::*;

    logic signed [ERR_WIDTH:0]   d1;
    logic signed [ERR_WIDTH+1:0] d2;
    logic signed [ERR_WIDTH:0]   op_p;
    logic signed [ERR_WIDTH+1:0] op_d;
    prod_t                       prod_reg;
    prod_t                       prod_next;

    // Positional uses e0 and e0-e1; incremental uses first and second difference
    always_comb begin
        d1   = (ERR_WIDTH+1)'(err.e0) - (ERR_WIDTH+1)'(err.e1);
        d2   = (ERR_WIDTH+2)'(err.e0) - ((ERR_WIDTH+2)'(err.e1) <<< 1)
             + (ERR_WIDTH+2)'(err.e2);
        op_p = (cfg.mode == MODE_POSITIONAL) ? (ERR_WIDTH+1)'(err.e0) : d1;
        op_d = (cfg.mode == MODE_POSITIONAL) ? (ERR_WIDTH+2)'(d1) : d2;
        prod_next.pa = PROD_WIDTH'(cfg.kp) * PROD_WIDTH'(op_p);
        prod_next.pi = PROD_WIDTH'(cfg.ki) * PROD_WIDTH'(err.e0);
        prod_next.pd = PROD_WIDTH'(cfg.kd) * PROD_WIDTH'(op_d);
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/dmpid_accum.sv
// ============================================================================
// dmpid_accum
// Combine stage and accumulate stage: sums the products, updates the output
// accumulator or integral, clamps, and converts to whole counts.
// ============================================================================
module dmpid_accum #(
    parameter int ACC_WIDTH      = dmpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = dmpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dmpid_pkg::cfg_t     cfg,
    input  logic                cmb_ld,
    input  logic                res_ld,
    input  dmpid_pkg::prod_t    prod,
    output dmpid_pkg::out_item_t res
);
    import dmpid_pkg::*;

    localparam int FIX_SHIFT = IN_FRAC + GAIN_FRAC_BITS;
    localparam int CSW       = PROD_WIDTH + 2;
    localparam int LW        = LIMIT_WIDTH + FIX_SHIFT + 1;
    localparam int SW0       = (ACC_WIDTH > CSW) ? ACC_WIDTH : CSW;
    localparam int SW        = ((SW0 > LW) ? SW0 : LW) + 2;

    localparam logic signed [SW-1:0] ACC_MAX =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN =
        {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] OUT_MAX = SW'(32'sd32767);
    localparam logic signed [SW-1:0] OUT_MIN = SW'(-32'sd32768);

    logic signed [CSW-1:0]        delta_reg;
    logic signed [CSW-1:0]        ppd_reg;
    logic signed [PROD_WIDTH-1:0] pi_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  acc_next;
    logic signed [ACC_WIDTH-1:0]  isum_reg;
    logic signed [ACC_WIDTH-1:0]  isum_next;
    out_item_t                    res_reg;
    out_item_t                    res_next;

    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] v_inc;
    logic signed [SW-1:0] v_pos;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] v_cl;
    logic                 hit_hi;
    logic                 hit_lo;

    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
        input logic signed [SW-1:0] x
    );
        logic signed [SW-1:0] y;
        y = x;
        if (x > ACC_MAX) begin
            y = ACC_MAX;
        end else if (x < ACC_MIN) begin
            y = ACC_MIN;
        end
        return y[ACC_WIDTH-1:0];
    endfunction

    // Q.F to counts, truncated toward zero, saturated to the output width
    function automatic logic signed [OUT_WIDTH-1:0] to_counts(
        input logic signed [SW-1:0] x
    );
        logic signed [SW-1:0] q;
        q = x >>> FIX_SHIFT;
        if (x[SW-1] && (x[FIX_SHIFT-1:0] != '0)) begin
            q = q + SW'(1);
        end
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
        end
        return q[OUT_WIDTH-1:0];
    endfunction

    // Combine stage
    always_ff @(posedge aclk) begin
        if (cmb_ld) begin
            delta_reg <= CSW'(prod.pa) + CSW'(prod.pi) + CSW'(prod.pd);
            ppd_reg   <= CSW'(prod.pa) + CSW'(prod.pd);
            pi_reg    <= prod.pi;
        end
    end

    // Accumulate, clamp and convert
    always_comb begin
        lim       = SW'({cfg.out_limit, {FIX_SHIFT{1'b0}}});
        v_inc     = SW'(sat_acc(SW'(acc_reg) + SW'(delta_reg)));
        isum_next = sat_acc(SW'(isum_reg) + SW'(pi_reg));
        v_pos     = SW'(ppd_reg) + SW'(isum_next);
        v         = (cfg.mode == MODE_POSITIONAL) ? v_pos : v_inc;
        hit_hi    = 1'b0;
        hit_lo    = 1'b0;
        v_cl      = v;
        if (v > lim) begin
            v_cl   = lim;
            hit_hi = 1'b1;
        end else if (v < -lim) begin
            v_cl   = -lim;
            hit_lo = 1'b1;
        end
        acc_next          = sat_acc(v_cl);
        res_next.drive    = to_counts(SW'(acc_next));
        res_next.clamped  = hit_hi | hit_lo;
        if (cfg.mode == MODE_POSITIONAL) begin
            res_next.integral_term = to_counts(SW'(isum_next));
        end else if (hit_hi) begin
            res_next.integral_term = signed'(OUT_WIDTH'(cfg.i_limit));
        end else if (hit_lo) begin
            res_next.integral_term = -signed'(OUT_WIDTH'(cfg.i_limit));
        end else begin
            res_next.integral_term = to_counts(SW'(pi_reg));
        end
    end

    // State: integral only moves in positional mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            isum_reg <= '0;
        end else if (res_ld) begin
            acc_reg <= acc_next;
            if (cfg.mode == MODE_POSITIONAL) begin
                isum_reg <= isum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ld) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/dual_mode_pid_controller_unit.sv
// ============================================================================
// dual_mode_pid_controller_unit
// Fixed-point PID controller, incremental or positional, with heading wrap.
// ============================================================================
// One item is accepted per clock while s_ready is high. Its result is offered
// on the result port after it has passed the input, error, multiply, combine
// and accumulate registers in turn. Throughput is one item per cycle as long
// as the result side keeps taking items. The controller state closes its loop
// inside the accumulate stage. That stage does one saturating add per item,
// one more add in positional mode, and one clamp. The configuration registers
// come out of reset as incremental mode, no wrap, zero gains, out_limit 1600
// and i_limit 800; write them only while no item is in flight.
module dual_mode_pid_controller_unit #(
    parameter int ACC_WIDTH      = dmpid_pkg::ACC_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = dmpid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [dmpid_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [dmpid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // input items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  dmpid_pkg::in_item_t                    s_item,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output dmpid_pkg::out_item_t                   m_item
);
    import dmpid_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  in_reg;
    err_t      err;
    prod_t     prod;

    logic v_in_reg, v_err_reg, v_mul_reg, v_cmb_reg, v_res_reg;
    logic rdy_in, rdy_err, rdy_mul, rdy_cmb, rdy_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= MODE_INCREMENTAL;
            cfg_reg.wrap_enable <= 1'b0;
            cfg_reg.kp          <= '0;
            cfg_reg.ki          <= '0;
            cfg_reg.kd          <= '0;
            cfg_reg.out_limit   <= RESET_OUT_LIMIT;
            cfg_reg.i_limit     <= RESET_I_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:        cfg_reg.mode        <= cfg_data[0];
                REG_WRAP_ENABLE: cfg_reg.wrap_enable <= cfg_data[0];
                REG_KP:          cfg_reg.kp          <= signed'(cfg_data[GAIN_WIDTH-1:0]);
                REG_KI:          cfg_reg.ki          <= signed'(cfg_data[GAIN_WIDTH-1:0]);
                REG_KD:          cfg_reg.kd          <= signed'(cfg_data[GAIN_WIDTH-1:0]);
                REG_OUT_LIMIT:   cfg_reg.out_limit   <= cfg_data[LIMIT_WIDTH-1:0];
                REG_I_LIMIT:     cfg_reg.i_limit     <= cfg_data[LIMIT_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // Per-stage ready: a stage loads when empty or when its item moves on
    assign rdy_res = !v_res_reg || m_ready;
    assign rdy_cmb = !v_cmb_reg || rdy_res;
    assign rdy_mul = !v_mul_reg || rdy_cmb;
    assign rdy_err = !v_err_reg || rdy_mul;
    assign rdy_in  = !v_in_reg  || rdy_err;
    assign s_ready = rdy_in;
    assign m_valid = v_res_reg;

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg  <= 1'b0;
            v_err_reg <= 1'b0;
            v_mul_reg <= 1'b0;
            v_cmb_reg <= 1'b0;
            v_res_reg <= 1'b0;
        end else begin
            if (rdy_in)  v_in_reg  <= s_valid;
            if (rdy_err) v_err_reg <= v_in_reg;
            if (rdy_mul) v_mul_reg <= v_err_reg;
            if (rdy_cmb) v_cmb_reg <= v_mul_reg;
            if (rdy_res) v_res_reg <= v_cmb_reg;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (rdy_in && s_valid) begin
            in_reg <= s_item;
        end
    end

    dmpid_err u_err (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wrap_enable (cfg_reg.wrap_enable),
        .ld          (rdy_err && v_in_reg),
        .in_item     (in_reg),
        .err         (err)
    );

    dmpid_mult u_mult (
        .aclk (aclk),
        .ld   (rdy_mul && v_err_reg),
        .cfg  (cfg_reg),
        .err  (err),
        .prod (prod)
    );

    dmpid_accum #(
        .ACC_WIDTH      (ACC_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmb_ld  (rdy_cmb && v_mul_reg),
        .res_ld  (rdy_res && v_cmb_reg),
        .prod    (prod),
        .res     (m_item)
    );

endmodule
